// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that check their own logic.
// Each macro expands to one labeled concurrent assertion on clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TKPI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// A condition that must never be true at a clock edge outside reset.
`define TKPI_NEVER(label, expr, msg) \
   `TKPI_ASSERT(label, !(expr), msg)

`endif

// ===== hw/rtl/tkpi_pkg.sv =====
// Package of the top-k pattern imputation unit: sizes, codes and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package tkpi_pkg;

   // Store sizes.
   localparam int WINDOW_MAX  = 256;
   localparam int SERIES_MAX  = 4;
   localparam int ANCHORS_MAX = 8;
   localparam int PLEN_MAX    = 128;
   localparam int SAMPLE_BITS = 16;

   // Field and register widths.
   localparam int POS_BITS       = $clog2(WINDOW_MAX);
   localparam int SER_BITS       = $clog2(SERIES_MAX);
   localparam int ROW_BITS       = $clog2(ANCHORS_MAX);
   localparam int TYPE_BITS      = 2;
   localparam int LEN_BITS       = 9;
   localparam int PLEN_BITS      = 8;
   localparam int K_BITS         = 4;
   localparam int D_BITS         = 3;
   localparam int X_BITS         = $clog2(PLEN_MAX);
   localparam int CSR_IDX_BITS   = 2;
   localparam int CSR_DATA_BITS  = 9;
   localparam int REF_ADDR_BITS  = SER_BITS + POS_BITS;
   localparam int COST_ADDR_BITS = ROW_BITS + POS_BITS;

   // Arithmetic widths.
   localparam int SQ_BITS   = 2 * SAMPLE_BITS;
   localparam int ACC_BITS  = 42;
   localparam int ROOT_BITS = ACC_BITS / 2;
   localparam int REM_BITS  = ROOT_BITS + 2;
   localparam int DIST_BITS = 24;
   localparam int COST_BITS = 32;
   localparam int SUM_BITS  = SAMPLE_BITS + ROW_BITS;
   localparam logic [COST_BITS-1:0] COST_INF = '1;

   // Request type codes.
   localparam logic [TYPE_BITS-1:0] REQ_LOAD_REF = 2'd0;
   localparam logic [TYPE_BITS-1:0] REQ_LOAD_TGT = 2'd1;
   localparam logic [TYPE_BITS-1:0] REQ_START    = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ANCHORS = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SERIES  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                      load_ref;
      logic                      load_tgt;
      logic                      ref_rd;
      logic [REF_ADDR_BITS-1:0]  ref_a_addr;
      logic [REF_ADDR_BITS-1:0]  ref_b_addr;
      logic                      acc_clear;
      logic                      sqrt_start;
      logic                      dist_wr;
      logic                      dist_rd;
      logic [POS_BITS-1:0]       dist_addr;
      logic                      cost_rd;
      logic [COST_ADDR_BITS-1:0] cost_a_addr;
      logic [COST_ADDR_BITS-1:0] cost_b_addr;
      logic                      cost_b_zero;
      logic                      cost_wr;
      logic [COST_ADDR_BITS-1:0] cost_wr_addr;
      logic                      cost_force_inf;
      logic                      tgt_rd;
      logic [POS_BITS-1:0]       tgt_addr;
      logic                      sum_clear;
      logic                      sum_add;
      logic                      div_start;
      logic [K_BITS-1:0]         div_k;
      logic                      rsp_load;
      logic                      rsp_err;
      logic                      tgt_wb;
      logic [POS_BITS-1:0]       wb_addr;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pipe_busy;
      logic sqrt_busy;
      logic div_busy;
      logic cost_eq;
      logic cost_inf;
   } status_type;

endpackage

// ===== hw/rtl/tkpi_if.sv =====
// Valid/ready channel interfaces of the imputation unit: request, response
// and configuration write. Depends on tkpi_pkg.
`timescale 1ns / 1ps

interface tkpi_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [tkpi_pkg::TYPE_BITS-1:0]        req_type;
   logic [tkpi_pkg::SER_BITS-1:0]         series_index;
   logic [tkpi_pkg::POS_BITS-1:0]         sample_index;
   logic signed [tkpi_pkg::SAMPLE_BITS-1:0] sample_value;
   logic [tkpi_pkg::POS_BITS-1:0]         missing_index;

   modport source (output valid, req_type, series_index, sample_index, sample_value,
                   missing_index, input ready);
   modport sink (input valid, req_type, series_index, sample_index, sample_value,
                 missing_index, output ready);
endinterface

interface tkpi_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [tkpi_pkg::SAMPLE_BITS-1:0] imputed_value;
   logic                                  config_error;

   modport source (output valid, imputed_value, config_error, input ready);
   modport sink (input valid, imputed_value, config_error, output ready);
endinterface

interface tkpi_csr_if;
   logic                                valid;
   logic                                ready;
   logic [tkpi_pkg::CSR_IDX_BITS-1:0]   index;
   logic [tkpi_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/tkpi_isqrt.sv =====
// Iterative integer floor square root, one result bit per cycle.
// Depends on tkpi_pkg.
`timescale 1ns / 1ps

module tkpi_isqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [tkpi_pkg::ACC_BITS-1:0]    radicand,
   output logic                             busy,
   output logic [tkpi_pkg::ROOT_BITS-1:0]   root
);

   localparam int CNT_BITS = $clog2(tkpi_pkg::ROOT_BITS + 1);
   localparam int SH_BITS  = tkpi_pkg::REM_BITS + 2;

   logic [tkpi_pkg::ACC_BITS-1:0]  rad_ff;
   logic [tkpi_pkg::REM_BITS-1:0]  rem_ff;
   logic [tkpi_pkg::ROOT_BITS-1:0] root_ff;
   logic [CNT_BITS-1:0]            cnt_ff;
   logic                           busy_ff;
   logic [SH_BITS-1:0]             rem_sh;
   logic [SH_BITS-1:0]             trial;
   logic                           fits;

   // Bring down the next two radicand bits and try the next root bit.
   assign rem_sh = {rem_ff, rad_ff[tkpi_pkg::ACC_BITS-1 -: 2]};
   assign trial  = SH_BITS'({root_ff, 2'b01});
   assign fits   = rem_sh >= trial;

   // Control: busy while root bits remain to be produced.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_BITS'(tkpi_pkg::ROOT_BITS);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Datapath of the digit recurrence.
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[tkpi_pkg::ACC_BITS-3:0], 2'b00};
         rem_ff  <= fits ? tkpi_pkg::REM_BITS'(rem_sh - trial)
                         : tkpi_pkg::REM_BITS'(rem_sh);
         root_ff <= {root_ff[tkpi_pkg::ROOT_BITS-2:0], fits};
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ===== hw/rtl/tkpi_dpath.sv =====
// Datapath of the imputation unit: sample, distance and cost memories, the
// distance pipeline, the cost update, averaging and divider. Uses tkpi_pkg, tkpi_isqrt.
`timescale 1ns / 1ps

module tkpi_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tkpi_pkg::cmd_type                      cmd,
   output tkpi_pkg::status_type                   status,
   input  logic [tkpi_pkg::SER_BITS-1:0]          series_index,
   input  logic [tkpi_pkg::POS_BITS-1:0]          sample_index,
   input  logic signed [tkpi_pkg::SAMPLE_BITS-1:0] sample_value,
   output logic signed [tkpi_pkg::SAMPLE_BITS-1:0] imputed_value,
   output logic                                   config_error
);

   localparam int SB       = tkpi_pkg::SAMPLE_BITS;
   localparam int REF_DEPTH  = tkpi_pkg::SERIES_MAX * tkpi_pkg::WINDOW_MAX;
   localparam int COST_DEPTH = tkpi_pkg::ANCHORS_MAX * tkpi_pkg::WINDOW_MAX;
   localparam int DCNT_BITS  = $clog2(tkpi_pkg::SUM_BITS + 1);
   localparam int KB         = tkpi_pkg::K_BITS;

   // Memories.
   logic [SB-1:0]                   ref_mem_ff  [REF_DEPTH];
   logic [SB-1:0]                   tgt_mem_ff  [tkpi_pkg::WINDOW_MAX];
   logic [tkpi_pkg::DIST_BITS-1:0]  dist_mem_ff [tkpi_pkg::WINDOW_MAX];
   logic [tkpi_pkg::COST_BITS-1:0]  cost_mem_ff [COST_DEPTH];

   // Distance pipeline.
   logic [SB-1:0]                  ra_ff, rb_ff;
   logic                           v1_ff, v2_ff;
   logic signed [SB:0]             diff;
   logic [SB:0]                    neg_diff;
   logic [SB-1:0]                  mag;
   logic [tkpi_pkg::SQ_BITS-1:0]   sq_w;
   logic [tkpi_pkg::SQ_BITS-1:0]   sq_ff;
   logic [tkpi_pkg::ACC_BITS-1:0]  acc_ff;
   logic                           sqrt_busy;
   logic [tkpi_pkg::ROOT_BITS-1:0] root;

   // Cost update.
   logic [tkpi_pkg::DIST_BITS-1:0] dist_ff;
   logic [tkpi_pkg::COST_BITS-1:0] cost_a_ff, cost_b_ff;
   logic                           b_zero_ff;
   logic [tkpi_pkg::COST_BITS-1:0] pred_cost, take_cost, new_cost;

   // Averaging and division.
   logic [SB-1:0]                  tdata_ff;
   logic signed [tkpi_pkg::SUM_BITS-1:0] sum_ff;
   logic [tkpi_pkg::SUM_BITS-1:0]  sum_neg;
   logic [tkpi_pkg::SUM_BITS-1:0]  dq_ff;
   logic [KB-1:0]                  drem_ff;
   logic [KB-1:0]                  dk_ff;
   logic                           dneg_ff;
   logic [DCNT_BITS-1:0]           dcnt_ff;
   logic                           dbusy_ff;
   logic [KB:0]                    drem_sh;
   logic                           dfits;
   logic [tkpi_pkg::SUM_BITS-1:0]  mean_w;
   logic [SB-1:0]                  imp_ff;
   logic                           err_ff;

   // Reference store: loads write, the distance sweep reads two samples a cycle.
   always_ff @(posedge clock) begin
      if (cmd.load_ref) begin
         ref_mem_ff[{series_index, sample_index}] <= sample_value;
      end
      if (cmd.ref_rd) begin
         ra_ff <= ref_mem_ff[cmd.ref_a_addr];
         rb_ff <= ref_mem_ff[cmd.ref_b_addr];
      end
   end

   // Difference magnitude and its square.
   assign diff     = $signed({ra_ff[SB-1], ra_ff}) - $signed({rb_ff[SB-1], rb_ff});
   assign neg_diff = -diff;
   assign mag      = diff[SB] ? neg_diff[SB-1:0] : diff[SB-1:0];
   assign sq_w     = mag * mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.ref_rd;
         v2_ff <= v1_ff;
      end
   end

   // Square stage and exact accumulation.
   always_ff @(posedge clock) begin
      sq_ff <= sq_w;
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + tkpi_pkg::ACC_BITS'(sq_ff);
      end
   end

   tkpi_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (acc_ff),
      .busy     (sqrt_busy),
      .root     (root)
   );

   // Distance store.
   always_ff @(posedge clock) begin
      if (cmd.dist_wr) begin
         dist_mem_ff[cmd.dist_addr] <= tkpi_pkg::DIST_BITS'(root);
      end
      if (cmd.dist_rd) begin
         dist_ff <= dist_mem_ff[cmd.dist_addr];
      end
   end

   // Cost table: one write and two registered reads a cycle.
   always_ff @(posedge clock) begin
      if (cmd.cost_wr) begin
         cost_mem_ff[cmd.cost_wr_addr] <= new_cost;
      end
      if (cmd.cost_rd) begin
         cost_a_ff <= cost_mem_ff[cmd.cost_a_addr];
         cost_b_ff <= cost_mem_ff[cmd.cost_b_addr];
         b_zero_ff <= cmd.cost_b_zero;
      end
   end

   // New cell: the cheaper of skipping this pattern and taking it; infinity saturates.
   assign pred_cost = b_zero_ff ? '0 : cost_b_ff;
   assign take_cost = (pred_cost == tkpi_pkg::COST_INF) ? tkpi_pkg::COST_INF :
                      pred_cost + tkpi_pkg::COST_BITS'(dist_ff);
   assign new_cost  = cmd.cost_force_inf ? tkpi_pkg::COST_INF :
                      ((cost_a_ff < take_cost) ? cost_a_ff : take_cost);

   // Target store: loads and the write-back of the mean share the write port.
   always_ff @(posedge clock) begin
      if (cmd.load_tgt) begin
         tgt_mem_ff[sample_index] <= sample_value;
      end else if (cmd.tgt_wb) begin
         tgt_mem_ff[cmd.wb_addr] <= mean_w[SB-1:0];
      end
      if (cmd.tgt_rd) begin
         tdata_ff <= tgt_mem_ff[cmd.tgt_addr];
      end
   end

   // Sum of the target samples after the anchors.
   always_ff @(posedge clock) begin
      if (cmd.sum_clear) begin
         sum_ff <= '0;
      end else if (cmd.sum_add) begin
         sum_ff <= sum_ff + tkpi_pkg::SUM_BITS'($signed(tdata_ff));
      end
   end

   // Restoring division of the sum magnitude by the anchor count.
   assign sum_neg = -sum_ff;
   assign drem_sh = {drem_ff, dq_ff[tkpi_pkg::SUM_BITS-1]};
   assign dfits   = drem_sh >= {1'b0, dk_ff};
   assign mean_w  = dneg_ff ? -dq_ff : dq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         dcnt_ff  <= '0;
      end else if (cmd.div_start) begin
         dbusy_ff <= 1'b1;
         dcnt_ff  <= DCNT_BITS'(tkpi_pkg::SUM_BITS);
      end else if (dbusy_ff) begin
         dcnt_ff <= dcnt_ff - 1'b1;
         if (dcnt_ff == DCNT_BITS'(1)) begin
            dbusy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dneg_ff <= sum_ff[tkpi_pkg::SUM_BITS-1];
         dq_ff   <= sum_ff[tkpi_pkg::SUM_BITS-1] ? sum_neg : sum_ff;
         drem_ff <= '0;
         dk_ff   <= cmd.div_k;
      end else if (dbusy_ff) begin
         drem_ff <= dfits ? KB'(drem_sh - {1'b0, dk_ff}) : KB'(drem_sh);
         dq_ff   <= {dq_ff[tkpi_pkg::SUM_BITS-2:0], dfits};
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         imp_ff <= cmd.rsp_err ? '0 : mean_w[SB-1:0];
         err_ff <= cmd.rsp_err;
      end
   end

   assign imputed_value    = imp_ff;
   assign config_error     = err_ff;
   assign status.pipe_busy = v1_ff | v2_ff;
   assign status.sqrt_busy = sqrt_busy;
   assign status.div_busy  = dbusy_ff;
   assign status.cost_eq   = cost_a_ff == cost_b_ff;
   assign status.cost_inf  = cost_a_ff == tkpi_pkg::COST_INF;

endmodule

// ===== hw/rtl/tkpi_ctrl.sv =====
// Controller of the imputation unit: configuration registers, the sequencer
// over distances, cost table, backtracking and averaging. Uses tkpi_pkg.
`timescale 1ns / 1ps

module tkpi_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic [tkpi_pkg::TYPE_BITS-1:0]       req_type,
   input  logic [tkpi_pkg::POS_BITS-1:0]        missing_index,
   output logic                                 req_ready,
   input  logic                                 csr_valid,
   input  logic [tkpi_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tkpi_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output logic                                 csr_ready,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output tkpi_pkg::cmd_type                    cmd,
   input  tkpi_pkg::status_type                 status
);

   localparam int PB  = tkpi_pkg::POS_BITS;
   localparam int LB  = tkpi_pkg::LEN_BITS;
   localparam int RB  = tkpi_pkg::ROW_BITS;
   localparam int PATB = LB + 2;

   typedef enum logic [4:0] {
      ST_IDLE, ST_REDUCE, ST_CHECK, ST_D_START, ST_D_ISSUE, ST_D_DRAIN, ST_D_SQRT,
      ST_D_WAIT, ST_DP_ISSUE, ST_DP_WRITE, ST_BT_ISSUE, ST_BT_EVAL, ST_AV_START,
      ST_AV_ISSUE, ST_AV_ADD, ST_AV_DIV, ST_AV_WAIT, ST_FINISH, ST_FAIL
   } state_type;

   state_type                         state_ff;
   logic [LB-1:0]                     win_ff;
   logic [tkpi_pkg::PLEN_BITS-1:0]    plen_ff;
   logic [tkpi_pkg::K_BITS-1:0]       k_ff;
   logic [tkpi_pkg::D_BITS-1:0]       d_ff;
   logic                              rsp_valid_ff;
   logic [LB-1:0]                     p_ff;
   logic [PB-1:0]                     pcnt_ff;
   logic [PB-1:0]                     j_ff;
   logic [tkpi_pkg::K_BITS-1:0]       i_ff;
   logic [tkpi_pkg::SER_BITS-1:0]     s_ff;
   logic [tkpi_pkg::X_BITS-1:0]       x_ff;
   logic [PB-1:0]                     a_ff, b_ff, a0_ff;
   logic [RB-1:0]                     av_ff;
   logic                              first_ff;
   logic [PB-1:0]                     anchor_ff [tkpi_pkg::ANCHORS_MAX];

   // Clamped configuration.
   logic [LB-1:0]                     len_c;
   logic [tkpi_pkg::PLEN_BITS-1:0]    plen_c;
   logic [tkpi_pkg::K_BITS-1:0]       k_c;
   logic [tkpi_pkg::D_BITS-1:0]       d_c;
   logic [PB-1:0]                     len_m1;
   logic signed [PATB-1:0]            pat_w;
   logic                              too_few;
   logic [LB:0]                       a0_sum;
   logic [PB-1:0]                     a0_init;
   logic [PB-1:0]                     pred;
   logic [RB-1:0]                     im1, im2;
   logic [PB-1:0]                     jm1;
   logic                              accept;
   logic                              x_last, s_last;
   logic [tkpi_pkg::K_BITS-1:0]       bt_i_n;
   logic [PB-1:0]                     bt_j_n;
   logic [LB:0]                       t_sum;
   logic [PB-1:0]                     t_addr;
   logic                              rsp_free;

   assign len_c  = (win_ff < LB'(2)) ? LB'(2) :
                   (win_ff > LB'(tkpi_pkg::WINDOW_MAX)) ? LB'(tkpi_pkg::WINDOW_MAX) : win_ff;
   assign plen_c = (plen_ff == '0) ? tkpi_pkg::PLEN_BITS'(1) :
                   (plen_ff > tkpi_pkg::PLEN_BITS'(tkpi_pkg::PLEN_MAX)) ?
                   tkpi_pkg::PLEN_BITS'(tkpi_pkg::PLEN_MAX) : plen_ff;
   assign k_c    = (k_ff == '0) ? tkpi_pkg::K_BITS'(1) :
                   (k_ff > tkpi_pkg::K_BITS'(tkpi_pkg::ANCHORS_MAX)) ?
                   tkpi_pkg::K_BITS'(tkpi_pkg::ANCHORS_MAX) : k_ff;
   assign d_c    = (d_ff == '0) ? tkpi_pkg::D_BITS'(1) :
                   (d_ff > tkpi_pkg::D_BITS'(tkpi_pkg::SERIES_MAX)) ?
                   tkpi_pkg::D_BITS'(tkpi_pkg::SERIES_MAX) : d_ff;
   assign len_m1 = PB'(len_c - 1'b1);

   // Pattern count and the check for too few patterns.
   assign pat_w   = $signed({2'b00, len_c}) - $signed({2'b00, plen_c, 1'b0}) +
                    $signed(PATB'(1));
   assign too_few = (pat_w < $signed(PATB'(1))) ||
                    ($signed(PATB'(k_c)) > pat_w);

   // First sample of the first candidate pattern, wrapped once.
   assign a0_sum  = (LB + 1)'(p_ff) + (LB + 1)'(plen_c);
   assign a0_init = (a0_sum >= (LB + 1)'(len_c)) ? PB'(a0_sum - (LB + 1)'(len_c))
                                                 : PB'(a0_sum);

   // Table indexes.
   assign pred = (j_ff >= plen_c) ? PB'(j_ff - plen_c) : '0;
   assign im1  = RB'(i_ff - 1'b1);
   assign im2  = RB'(i_ff - 2'd2);
   assign jm1  = j_ff - 1'b1;

   assign x_last = (tkpi_pkg::PLEN_BITS'(x_ff) == plen_c - 1'b1);
   assign s_last = (tkpi_pkg::D_BITS'(s_ff) == d_c - 1'b1);

   // Backtracking step: move left on a tie, otherwise record the anchor.
   always_comb begin
      if (status.cost_eq) begin
         bt_i_n = i_ff;
         bt_j_n = jm1;
      end else begin
         bt_i_n = i_ff - 1'b1;
         bt_j_n = pred;
      end
   end

   // Target position that follows the current anchor, wrapped once.
   assign t_sum  = (LB + 1)'(p_ff) + (LB + 1)'(plen_c) + (LB + 1)'(anchor_ff[av_ff]) -
                   (LB + 1)'(1);
   assign t_addr = (t_sum >= (LB + 1)'(len_c)) ? PB'(t_sum - (LB + 1)'(len_c))
                                               : PB'(t_sum);

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Commands to the datapath.
   always_comb begin
      cmd              = '0;
      cmd.load_ref     = accept && (req_type == tkpi_pkg::REQ_LOAD_REF);
      cmd.load_tgt     = accept && (req_type == tkpi_pkg::REQ_LOAD_TGT);
      cmd.ref_a_addr   = {s_ff, a_ff};
      cmd.ref_b_addr   = {s_ff, b_ff};
      cmd.dist_addr    = j_ff;
      cmd.cost_wr_addr = {im1, j_ff};
      cmd.cost_force_inf = PB'(i_ff) > j_ff;
      cmd.tgt_addr     = t_addr;
      cmd.div_k        = k_c;
      cmd.wb_addr      = p_ff[PB-1:0];
      case (state_ff)
         ST_D_START: begin
            cmd.acc_clear = 1'b1;
         end
         ST_D_ISSUE: begin
            cmd.ref_rd = 1'b1;
         end
         ST_D_SQRT: begin
            cmd.sqrt_start = 1'b1;
         end
         ST_D_WAIT: begin
            cmd.dist_wr = !status.sqrt_busy;
         end
         ST_DP_ISSUE: begin
            cmd.cost_rd     = 1'b1;
            cmd.dist_rd     = 1'b1;
            cmd.cost_a_addr = {im1, jm1};
            cmd.cost_b_addr = {im2, pred};
            cmd.cost_b_zero = (i_ff == tkpi_pkg::K_BITS'(1));
         end
         ST_DP_WRITE: begin
            cmd.cost_wr = 1'b1;
         end
         ST_BT_ISSUE: begin
            cmd.cost_rd     = 1'b1;
            cmd.cost_a_addr = {im1, j_ff};
            cmd.cost_b_addr = {im1, jm1};
         end
         ST_AV_START: begin
            cmd.sum_clear = 1'b1;
         end
         ST_AV_ISSUE: begin
            cmd.tgt_rd = 1'b1;
         end
         ST_AV_ADD: begin
            cmd.sum_add = 1'b1;
         end
         ST_AV_DIV: begin
            cmd.div_start = 1'b1;
         end
         ST_FINISH: begin
            cmd.rsp_load = rsp_free;
            cmd.tgt_wb   = rsp_free;
         end
         ST_FAIL: begin
            cmd.rsp_load = rsp_free;
            cmd.rsp_err  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Sequencer, configuration registers and the result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         win_ff       <= LB'(tkpi_pkg::WINDOW_MAX);
         plen_ff      <= tkpi_pkg::PLEN_BITS'(8);
         k_ff         <= tkpi_pkg::K_BITS'(4);
         d_ff         <= tkpi_pkg::D_BITS'(3);
      end else begin
         if (csr_valid) begin
            case (csr_index)
               tkpi_pkg::CSR_WINDOW:  win_ff  <= csr_data;
               tkpi_pkg::CSR_PATTERN: plen_ff <= csr_data[tkpi_pkg::PLEN_BITS-1:0];
               tkpi_pkg::CSR_ANCHORS: k_ff    <= csr_data[tkpi_pkg::K_BITS-1:0];
               tkpi_pkg::CSR_SERIES:  d_ff    <= csr_data[tkpi_pkg::D_BITS-1:0];
               default: begin
               end
            endcase
         end

         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_type == tkpi_pkg::REQ_START)) begin
                  p_ff     <= LB'(missing_index);
                  state_ff <= ST_REDUCE;
               end
            end
            // Bring the missing position into the window.
            ST_REDUCE: begin
               if (p_ff >= len_c) begin
                  p_ff <= p_ff - len_c;
               end else begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (too_few) begin
                  state_ff <= ST_FAIL;
               end else begin
                  pcnt_ff  <= PB'(pat_w);
                  j_ff     <= PB'(1);
                  a0_ff    <= a0_init;
                  state_ff <= ST_D_START;
               end
            end
            // Distance of candidate pattern j.
            ST_D_START: begin
               s_ff     <= '0;
               x_ff     <= '0;
               a_ff     <= a0_ff;
               b_ff     <= p_ff[PB-1:0];
               state_ff <= ST_D_ISSUE;
            end
            ST_D_ISSUE: begin
               if (x_last) begin
                  x_ff <= '0;
                  a_ff <= a0_ff;
                  b_ff <= p_ff[PB-1:0];
                  s_ff <= s_ff + 1'b1;
                  if (s_last) begin
                     state_ff <= ST_D_DRAIN;
                  end
               end else begin
                  x_ff <= x_ff + 1'b1;
                  a_ff <= (a_ff == '0) ? len_m1 : a_ff - 1'b1;
                  b_ff <= (b_ff == '0) ? len_m1 : b_ff - 1'b1;
               end
            end
            ST_D_DRAIN: begin
               if (!status.pipe_busy) begin
                  state_ff <= ST_D_SQRT;
               end
            end
            ST_D_SQRT: begin
               state_ff <= ST_D_WAIT;
            end
            ST_D_WAIT: begin
               if (!status.sqrt_busy) begin
                  if (j_ff == pcnt_ff) begin
                     j_ff     <= '0;
                     i_ff     <= tkpi_pkg::K_BITS'(1);
                     state_ff <= ST_DP_ISSUE;
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     a0_ff    <= (a0_ff == len_m1) ? '0 : a0_ff + 1'b1;
                     state_ff <= ST_D_START;
                  end
               end
            end
            // Cost table, column by column.
            ST_DP_ISSUE: begin
               state_ff <= ST_DP_WRITE;
            end
            ST_DP_WRITE: begin
               state_ff <= ST_DP_ISSUE;
               if (i_ff == k_c) begin
                  i_ff <= tkpi_pkg::K_BITS'(1);
                  if (j_ff == pcnt_ff) begin
                     i_ff     <= k_c;
                     first_ff <= 1'b1;
                     state_ff <= ST_BT_ISSUE;
                  end else begin
                     j_ff <= j_ff + 1'b1;
                  end
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            // Backtracking from the last cell.
            ST_BT_ISSUE: begin
               state_ff <= ST_BT_EVAL;
            end
            ST_BT_EVAL: begin
               if (first_ff && status.cost_inf) begin
                  state_ff <= ST_FAIL;
               end else begin
                  first_ff <= 1'b0;
                  if (!status.cost_eq) begin
                     anchor_ff[im1] <= j_ff;
                  end
                  i_ff <= bt_i_n;
                  j_ff <= bt_j_n;
                  if ((bt_i_n == '0) || (bt_j_n == '0)) begin
                     state_ff <= ST_AV_START;
                  end else begin
                     state_ff <= ST_BT_ISSUE;
                  end
               end
            end
            // Average of the target samples after the anchors.
            ST_AV_START: begin
               av_ff    <= '0;
               state_ff <= ST_AV_ISSUE;
            end
            ST_AV_ISSUE: begin
               state_ff <= ST_AV_ADD;
            end
            ST_AV_ADD: begin
               if (tkpi_pkg::K_BITS'(av_ff) == k_c - 1'b1) begin
                  state_ff <= ST_AV_DIV;
               end else begin
                  av_ff    <= av_ff + 1'b1;
                  state_ff <= ST_AV_ISSUE;
               end
            end
            ST_AV_DIV: begin
               state_ff <= ST_AV_WAIT;
            end
            ST_AV_WAIT: begin
               if (!status.div_busy) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH, ST_FAIL: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/top_k_pattern_imputation_unit.sv =====
// Top-k pattern imputation unit. Load items are accepted one per cycle while the
// unit is idle. During a start item the distance sweep reads one sample pair a cycle
// and the square root and the divider give one bit a cycle. Uses tkpi_pkg, tkpi_if,
// tkpi_ctrl, tkpi_dpath.
// Synchronous reset loads the register defaults; sample stores are undefined until loaded.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module top_k_pattern_imputation_unit (
   input  logic        clock,
   input  logic        reset,
   tkpi_req_if.sink    req_ch,
   tkpi_rsp_if.source  rsp_ch,
   tkpi_csr_if.sink    csr_ch
);

   tkpi_pkg::cmd_type    cmd;
   tkpi_pkg::status_type status;

   // Sequencer.
   tkpi_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_type      (req_ch.req_type),
      .missing_index (req_ch.missing_index),
      .req_ready     (req_ch.ready),
      .csr_valid     (csr_ch.valid),
      .csr_index     (csr_ch.index),
      .csr_data      (csr_ch.data),
      .csr_ready     (csr_ch.ready),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .cmd           (cmd),
      .status        (status)
   );

   // Stores and arithmetic.
   tkpi_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .series_index  (req_ch.series_index),
      .sample_index  (req_ch.sample_index),
      .sample_value  (req_ch.sample_value),
      .imputed_value (rsp_ch.imputed_value),
      .config_error  (rsp_ch.config_error)
   );

   // The write-back of the mean never collides with a target load.
   `TKPI_NEVER(a_wb_vs_load, cmd.tgt_wb && cmd.load_tgt, "write-back collides with a load")
   // A start item stops intake until its result is prepared.
   `TKPI_ASSERT(a_start_blocks, (req_ch.valid && req_ch.ready && req_ch.req_type == tkpi_pkg::REQ_START) |=> !req_ch.ready, "intake open after a start item")
   // The square root unit is started only when it is free.
   `TKPI_ASSERT(a_sqrt_free, cmd.sqrt_start |-> !status.sqrt_busy, "square root restarted while busy")
   // The cost table is never read and written in the same cycle.
   `TKPI_NEVER(a_cost_port, cmd.cost_wr && cmd.cost_rd, "cost table read and write together")

endmodule
